// ----- rtl/core/sgc_pkg.sv -----
package sgc_pkg;

  // face geometry
  localparam int MAX_FACE_SIZE = 1024;
  localparam int FACE_W = 3;
  localparam int POS_W = 10;
  localparam int SIZE_W = 11;
  localparam int N_W = $clog2(MAX_FACE_SIZE) + 1;
  localparam int FRAC = 16;

  // magnitude of 2*pos+1-n and the fixed point coordinate
  localparam int MAG_W = (POS_W + 1 > N_W) ? POS_W + 1 : N_W;
  localparam int NUM_W = MAG_W + 2;
  localparam int Q_W = MAG_W + FRAC;

  // squared length and its root
  localparam int SQ_W = 2 * Q_W;
  localparam int SUM_W = SQ_W + 2;
  localparam int LEN_W = SUM_W / 2;

  // vertical component and normalized result
  localparam int V_W = Q_W;
  localparam int DV_W = V_W + FRAC;
  localparam int NY_W = FRAC + 1;
  localparam int NYS_W = NY_W + 1;
  localparam int TN_W = NYS_W + 3;
  localparam int TP_W = 19;
  localparam int T_W = FRAC + 1;
  localparam int RECIP_SHIFT = 20;
  localparam logic [TP_W-1:0] RECIP3 = TP_W'(((1 << RECIP_SHIFT) + 2) / 3);

  localparam int ONE_Q16 = 1 << FRAC;
  localparam int HALF_Q16 = 1 << (FRAC - 1);

  // colors
  localparam int COLOR_W = 48;
  localparam int CH_W = 16;
  localparam int N_CH = 3;

  // register file
  localparam int PDATA_W = 64;
  localparam int PADDR_W = 5;
  localparam logic [SIZE_W-1:0] FACE_SIZE_RST = SIZE_W'(256);
  localparam logic [COLOR_W-1:0] SKY_TOP_RST = 48'h40008000D99A;
  localparam logic [COLOR_W-1:0] HORIZON_RST = 48'hB852C7AED99A;
  localparam logic [COLOR_W-1:0] GROUND_RST = 48'h6148570A47AE;

  typedef enum logic [1:0] {
    REG_FACE_SIZE,
    REG_SKY_TOP,
    REG_HORIZON,
    REG_GROUND
  } reg_index_t;

  // face codes
  localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

endpackage

// ----- rtl/core/sgc_stream_if.sv -----
interface sgc_in_if import sgc_pkg::*; ();
  logic valid;
  logic ready;
  logic [FACE_W-1:0] face;
  logic [POS_W-1:0] column;
  logic [POS_W-1:0] row;

  modport source (output valid, face, column, row, input ready);
  modport sink (input valid, face, column, row, output ready);
endinterface

interface sgc_out_if import sgc_pkg::*; ();
  logic valid;
  logic ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

// ----- rtl/core/sky_gradient_cubemap_texel_unit.sv -----
// throughput: one texel per cycle while the output is not stalled; the quotient, square root and normalizing
//   divide are each unrolled one result bit per pipeline stage
// a stalled output holds every stage in place, no bubbles are squeezed out
// reset (rst, synchronous) empties the pipeline and loads the register defaults
module sky_gradient_cubemap_texel_unit import sgc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  sgc_in_if.sink              texel_in,
  sgc_out_if.source           pixel_out,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // ---------------------------------------------------------------------------
  // stage types
  // ---------------------------------------------------------------------------
  // one lane of the texel coordinate divider: (mag << 16) / n
  typedef struct packed {
    logic [N_W-1:0] r;
    logic [Q_W-1:0] q;
    logic [Q_W-1:0] d;
  } da_lane_t;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic              sx;
    logic              sy;
    da_lane_t          lx;
    da_lane_t          ly;
  } da_t;

  // digit-by-digit square root, two radicand bits per stage
  typedef struct packed {
    logic [V_W-1:0]     vmag;
    logic               vneg;
    logic [LEN_W+1:0]   rem;
    logic [LEN_W-1:0]   root;
    logic [SUM_W-1:0]   s;
  } sq_t;

  // normalizing divide (|v| << 16) / len
  typedef struct packed {
    logic             vneg;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] rem;
    logic [NY_W-1:0]  q;
    logic [NY_W-1:0]  d;
  } db_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0]  face_size;
  logic [COLOR_W-1:0] sky_top_color;
  logic [COLOR_W-1:0] horizon_color;
  logic [COLOR_W-1:0] ground_color;
  reg_index_t         cfg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_index_t'(paddr[PADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_size     <= FACE_SIZE_RST;
      sky_top_color <= SKY_TOP_RST;
      horizon_color <= HORIZON_RST;
      ground_color  <= GROUND_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FACE_SIZE: face_size     <= pwdata[SIZE_W-1:0];
        REG_SKY_TOP:   sky_top_color <= pwdata[COLOR_W-1:0];
        REG_HORIZON:   horizon_color <= pwdata[COLOR_W-1:0];
        REG_GROUND:    ground_color  <= pwdata[COLOR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FACE_SIZE: prdata = PDATA_W'(face_size);
      REG_SKY_TOP:   prdata = PDATA_W'(sky_top_color);
      REG_HORIZON:   prdata = PDATA_W'(horizon_color);
      REG_GROUND:    prdata = PDATA_W'(ground_color);
    endcase
  end

  // effective face size: zero reads as one, oversize saturates
  logic [N_W-1:0] n_eff;
  always_comb begin
    if (face_size == '0) begin
      n_eff = N_W'(1);
    end else if (int'(face_size) > MAX_FACE_SIZE) begin
      n_eff = N_W'(MAX_FACE_SIZE);
    end else begin
      n_eff = N_W'(face_size);
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline advance: every stage moves together unless the output is stuck
  // ---------------------------------------------------------------------------
  logic adv;
  logic o_vld;
  assign adv            = !o_vld || pixel_out.ready;
  assign texel_in.ready = adv;

  // ---------------------------------------------------------------------------
  // stage 0: input capture
  // ---------------------------------------------------------------------------
  logic              v_s0;
  logic [FACE_W-1:0] s0_face;
  logic [POS_W-1:0]  s0_col;
  logic [POS_W-1:0]  s0_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s0 <= 1'b0;
    end else if (adv) begin
      v_s0 <= texel_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_face <= texel_in.face;
      s0_col  <= texel_in.column;
      s0_row  <= texel_in.row;
    end
  end

  // signed 2*pos+1-n and its magnitude
  logic signed [NUM_W-1:0] numx, numy;
  logic [MAG_W-1:0]        magx, magy;
  da_t                     da_init;

  always_comb begin
    numx = $signed({{(NUM_W-POS_W-1){1'b0}}, s0_col, 1'b1})
         - $signed({{(NUM_W-N_W){1'b0}}, n_eff});
    numy = $signed({{(NUM_W-POS_W-1){1'b0}}, s0_row, 1'b1})
         - $signed({{(NUM_W-N_W){1'b0}}, n_eff});
    magx = numx[NUM_W-1] ? MAG_W'(-numx) : MAG_W'(numx);
    magy = numy[NUM_W-1] ? MAG_W'(-numy) : MAG_W'(numy);
    da_init.face = s0_face;
    da_init.sx   = numx[NUM_W-1];
    da_init.sy   = numy[NUM_W-1];
    da_init.lx.r = '0;
    da_init.lx.q = '0;
    da_init.lx.d = {magx, {FRAC{1'b0}}};
    da_init.ly.r = '0;
    da_init.ly.q = '0;
    da_init.ly.d = {magy, {FRAC{1'b0}}};
  end

  // ---------------------------------------------------------------------------
  // coordinate divider: one quotient bit per stage, x and y side by side
  // ---------------------------------------------------------------------------
  function automatic da_lane_t da_step(da_lane_t s, logic [N_W-1:0] n);
    logic [N_W:0] tr;
    da_lane_t     o;
    tr = {s.r, s.d[Q_W-1]};
    o.d = {s.d[Q_W-2:0], 1'b0};
    if (tr >= {1'b0, n}) begin
      o.r = N_W'(tr - {1'b0, n});
      o.q = {s.q[Q_W-2:0], 1'b1};
    end else begin
      o.r = N_W'(tr);
      o.q = {s.q[Q_W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [Q_W-1:0] da_v;
  da_t            da_r [Q_W];
  da_t            da_n [Q_W];

  always_comb begin
    da_t src;
    for (int k = 0; k < Q_W; k++) begin
      src        = (k == 0) ? da_init : da_r[(k == 0) ? 0 : k - 1];
      da_n[k]    = src;
      da_n[k].lx = da_step(src.lx, n_eff);
      da_n[k].ly = da_step(src.ly, n_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      da_v <= '0;
    end else if (adv) begin
      da_v <= {da_v[Q_W-2:0], v_s0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < Q_W; k++) begin
        da_r[k] <= da_n[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // squares and vertical component
  // ---------------------------------------------------------------------------
  da_t            da_last;
  logic [V_W-1:0] vmag;
  logic           vneg;
  logic           v_m;
  logic [SQ_W-1:0] m_sqx, m_sqy;
  logic [V_W-1:0] m_vmag;
  logic           m_vneg;

  assign da_last = da_r[Q_W-1];

  always_comb begin
    case (da_last.face) inside
      FACE_POS_Y: begin
        vmag = V_W'(ONE_Q16);
        vneg = 1'b0;
      end
      FACE_NEG_Y: begin
        vmag = V_W'(ONE_Q16);
        vneg = 1'b1;
      end
      FACE_POS_X, FACE_NEG_X, FACE_POS_Z, FACE_NEG_Z: begin
        // side faces look along -ty
        vmag = da_last.ly.q;
        vneg = !da_last.sy;
      end
      default: begin
        vmag = '0;
        vneg = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m <= 1'b0;
    end else if (adv) begin
      v_m <= da_v[Q_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_sqx  <= da_last.lx.q * da_last.lx.q;
      m_sqy  <= da_last.ly.q * da_last.ly.q;
      m_vmag <= vmag;
      m_vneg <= vneg;
    end
  end

  // length squared: 1 + tx^2 + ty^2 in q32
  logic             v_sum;
  logic [SUM_W-1:0] sum_r;
  logic [V_W-1:0]   sum_vmag;
  logic             sum_vneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_sum <= 1'b0;
    end else if (adv) begin
      v_sum <= v_m;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r    <= (SUM_W'(1) << (2 * FRAC)) + SUM_W'(m_sqx) + SUM_W'(m_sqy);
      sum_vmag <= m_vmag;
      sum_vneg <= m_vneg;
    end
  end

  // ---------------------------------------------------------------------------
  // square root: one root bit per stage
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] sq_v;
  sq_t              sq_r [LEN_W];
  sq_t              sq_n [LEN_W];
  sq_t              sq_init;

  always_comb begin
    sq_init.vmag = sum_vmag;
    sq_init.vneg = sum_vneg;
    sq_init.rem  = '0;
    sq_init.root = '0;
    sq_init.s    = sum_r;
  end

  always_comb begin
    sq_t              src;
    logic [LEN_W+3:0] remt;
    logic [LEN_W+3:0] trial;
    for (int k = 0; k < LEN_W; k++) begin
      src      = (k == 0) ? sq_init : sq_r[(k == 0) ? 0 : k - 1];
      remt     = {src.rem, src.s[SUM_W-1 -: 2]};
      trial    = {2'b00, src.root, 2'b01};
      sq_n[k]  = src;
      sq_n[k].s = {src.s[SUM_W-3:0], 2'b00};
      if (remt >= trial) begin
        sq_n[k].rem  = (LEN_W+2)'(remt - trial);
        sq_n[k].root = {src.root[LEN_W-2:0], 1'b1};
      end else begin
        sq_n[k].rem  = (LEN_W+2)'(remt);
        sq_n[k].root = {src.root[LEN_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= '0;
    end else if (adv) begin
      sq_v <= {sq_v[LEN_W-2:0], v_sum};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < LEN_W; k++) begin
        sq_r[k] <= sq_n[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // normalizing divide: quotient stays within 17 bits since len >= |v|
  // ---------------------------------------------------------------------------
  logic [NY_W-1:0] db_v;
  db_t             db_r [NY_W];
  db_t             db_n [NY_W];
  db_t             db_init;
  logic [DV_W-1:0] dvd;

  always_comb begin
    dvd          = {sq_r[LEN_W-1].vmag, {FRAC{1'b0}}};
    db_init.vneg = sq_r[LEN_W-1].vneg;
    db_init.len  = sq_r[LEN_W-1].root;
    db_init.rem  = LEN_W'(dvd[DV_W-1:NY_W]);
    db_init.q    = '0;
    db_init.d    = dvd[NY_W-1:0];
  end

  always_comb begin
    db_t            src;
    logic [LEN_W:0] tr;
    for (int k = 0; k < NY_W; k++) begin
      src       = (k == 0) ? db_init : db_r[(k == 0) ? 0 : k - 1];
      tr        = {src.rem, src.d[NY_W-1]};
      db_n[k]   = src;
      db_n[k].d = {src.d[NY_W-2:0], 1'b0};
      if (tr >= {1'b0, src.len}) begin
        db_n[k].rem = LEN_W'(tr - {1'b0, src.len});
        db_n[k].q   = {src.q[NY_W-2:0], 1'b1};
      end else begin
        db_n[k].rem = LEN_W'(tr);
        db_n[k].q   = {src.q[NY_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      db_v <= '0;
    end else if (adv) begin
      db_v <= {db_v[NY_W-2:0], sq_v[LEN_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NY_W; k++) begin
        db_r[k] <= db_n[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // blend factor t = (5*ny + 1) / 3, divide by 3 as reciprocal multiply
  // ---------------------------------------------------------------------------
  logic signed [NYS_W-1:0] ny;
  logic signed [TN_W-1:0]  tnum;
  logic                    v_t1;
  logic                    t1_pos;
  logic [2*TP_W-1:0]       t1_prod;

  always_comb begin
    ny   = db_r[NY_W-1].vneg ? -$signed({1'b0, db_r[NY_W-1].q})
                             : $signed({1'b0, db_r[NY_W-1].q});
    tnum = TN_W'(ny * 5 + ONE_Q16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_t1 <= 1'b0;
    end else if (adv) begin
      v_t1 <= db_v[NY_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_pos  <= tnum > 0;
      t1_prod <= tnum[TP_W-1:0] * RECIP3;
    end
  end

  // clamp, then pick the gradient segment and its local factor
  logic [2*TP_W-RECIP_SHIFT-1:0] traw;
  logic [T_W-1:0]                tval;
  logic                          v_t2;
  logic                          t2_hi;
  logic [T_W-1:0]                t2_f;

  always_comb begin
    traw = t1_prod[2*TP_W-1:RECIP_SHIFT];
    if (!t1_pos) begin
      tval = '0;
    end else if (traw > (2*TP_W-RECIP_SHIFT)'(ONE_Q16)) begin
      tval = T_W'(ONE_Q16);
    end else begin
      tval = T_W'(traw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_t2 <= 1'b0;
    end else if (adv) begin
      v_t2 <= v_t1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_hi <= tval >= T_W'(HALF_Q16);
      t2_f  <= (tval >= T_W'(HALF_Q16)) ? T_W'((tval - T_W'(HALF_Q16)) << 1)
                                        : T_W'(tval << 1);
    end
  end

  // ---------------------------------------------------------------------------
  // per channel weights: a*(1-f) and b*f
  // ---------------------------------------------------------------------------
  logic [COLOR_W-1:0] col_a, col_b;
  logic [T_W-1:0]     fc;
  logic               v_t3;
  logic [CH_W+T_W-1:0] t3_pa [N_CH];
  logic [CH_W+T_W-1:0] t3_pb [N_CH];

  assign col_a = t2_hi ? horizon_color : ground_color;
  assign col_b = t2_hi ? sky_top_color : horizon_color;
  assign fc    = T_W'(ONE_Q16) - t2_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_t3 <= 1'b0;
    end else if (adv) begin
      v_t3 <= v_t2;
    end
  end

  // channel 0 is red in the top bits
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < N_CH; c++) begin
        t3_pa[c] <= col_a[(N_CH-1-c)*CH_W +: CH_W] * fc;
        t3_pb[c] <= col_b[(N_CH-1-c)*CH_W +: CH_W] * t2_f;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic [CH_W+T_W:0] mix [N_CH];
  logic [CH_W-1:0]   o_ch [N_CH];

  always_comb begin
    for (int c = 0; c < N_CH; c++) begin
      mix[c] = (CH_W+T_W+1)'(t3_pa[c]) + (CH_W+T_W+1)'(t3_pb[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (adv) begin
      o_vld <= v_t3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < N_CH; c++) begin
        o_ch[c] <= mix[c][FRAC +: CH_W];
      end
    end
  end

  assign pixel_out.valid = o_vld;
  assign pixel_out.red   = o_ch[0];
  assign pixel_out.green = o_ch[1];
  assign pixel_out.blue  = o_ch[2];

`ifndef NO_ASSERTIONS
  // the vector length never drops below one
  a_len_min: assert property (@(posedge clk) disable iff (rst)
    sq_v[LEN_W-1] |-> sq_r[LEN_W-1].root >= LEN_W'(ONE_Q16))
    else $error("vector length below one");

  // normalized component stays within -1..1
  a_ny_range: assert property (@(posedge clk) disable iff (rst)
    db_v[NY_W-1] |-> db_r[NY_W-1].q <= NY_W'(ONE_Q16))
    else $error("normalized component out of range");

  // local blend factor within 0..1
  a_f_range: assert property (@(posedge clk) disable iff (rst)
    v_t2 |-> t2_f <= T_W'(ONE_Q16))
    else $error("blend factor out of range");

  // pipeline comes out of reset empty
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !o_vld && (v_t3 == 1'b0))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ----- verif/sgc_tb_if.sv -----
interface sgc_tb_apb_if import sgc_pkg::*; ();
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;
endinterface

// ----- verif/sky_texel_checker.sv -----
module sky_texel_checker import sgc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  sgc_in_if.sink       texel_in,
  sgc_out_if.sink      pixel_out,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int           fail_count,
  output int           pending,
  output int           texels_seen,
  output int           pixels_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  logic [SIZE_W-1:0] size_q;
  logic [COLOR_W-1:0] sky_q, horizon_q, ground_q;
  rgb_t color_fifo[$];

  assign pending = color_fifo.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint centre_q16(longint p, longint n);
    longint num, mag;
    num = 2 * p + 1 - n;
    mag = num < 0 ? -num : num;
    return num < 0 ? -((mag << 16) / n) : (mag << 16) / n;
  endfunction

  function automatic rgb_t sky_color(logic [2:0] face, logic [9:0] col, logic [9:0] row);
    longint n, tx, ty, v, ny, num, t, f, mag;
    longint unsigned len;
    logic [COLOR_W-1:0] a, b;
    logic [CH_W-1:0] ch [3];
    n = size_q;
    if (n == 0) n = 1;
    if (n > MAX_FACE_SIZE) n = MAX_FACE_SIZE;
    tx = centre_q16(col, n);
    ty = centre_q16(row, n);
    if (face == FACE_POS_Y) v = ONE_Q16;
    else if (face == FACE_NEG_Y) v = -ONE_Q16;
    else if (face <= FACE_NEG_Z) v = -ty;
    else v = 0;
    len = int_sqrt((64'd1 << 32) + tx * tx + ty * ty);
    mag = v < 0 ? -v : v;
    ny = (mag << 16) / longint'(len);
    if (v < 0) ny = -ny;
    num = 5 * ny + ONE_Q16;
    if (num <= 0) t = 0;
    else begin
      t = num / 3;
      if (t > ONE_Q16) t = ONE_Q16;
    end
    if (t < HALF_Q16) begin
      f = 2 * t; a = ground_q; b = horizon_q;
    end else begin
      f = 2 * (t - HALF_Q16); a = horizon_q; b = sky_q;
    end
    for (int k = 0; k < 3; k++) begin
      longint ca, cb;
      ca = (a >> (32 - 16 * k)) & 16'hFFFF;
      cb = (b >> (32 - 16 * k)) & 16'hFFFF;
      ch[k] = CH_W'((ca * (ONE_Q16 - f) + cb * f) >> 16);
    end
    return '{red: ch[0], green: ch[1], blue: ch[2]};
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      size_q <= FACE_SIZE_RST;
      sky_q <= SKY_TOP_RST;
      horizon_q <= HORIZON_RST;
      ground_q <= GROUND_RST;
      color_fifo.delete();
      fail_count = 0;
      texels_seen <= 0;
      pixels_seen <= 0;
    end else begin
      if (pixel_out.valid && pixel_out.ready) begin
        pixels_seen <= pixels_seen + 1;
        if (color_fifo.size() == 0) report_mismatch("unexpected beat", 0, 0);
        else begin
          rgb_t want;
          want = color_fifo.pop_front();
          if (pixel_out.red !== want.red) report_mismatch("red", pixel_out.red, want.red);
          if (pixel_out.green !== want.green)
            report_mismatch("green", pixel_out.green, want.green);
          if (pixel_out.blue !== want.blue) report_mismatch("blue", pixel_out.blue, want.blue);
        end
      end
      if (texel_in.valid && texel_in.ready) begin
        color_fifo.push_back(sky_color(texel_in.face, texel_in.column, texel_in.row));
        texels_seen <= texels_seen + 1;
      end
      // register writes land after this edge's prediction
      if (psel && penable && pwrite && pready) begin
        case (paddr >> 3)
          REG_FACE_SIZE: size_q <= pwdata[SIZE_W-1:0];
          REG_SKY_TOP:   sky_q <= pwdata[COLOR_W-1:0];
          REG_HORIZON:   horizon_q <= pwdata[COLOR_W-1:0];
          REG_GROUND:    ground_q <= pwdata[COLOR_W-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- verif/tb.sv -----
module tb import sgc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 79;
  localparam int STALL_LIMIT = 20000;

  logic clk, rst;
  int fail_count, pending, texels_seen, pixels_seen;
  int send_idle_pct, recv_stall_pct;
  int hold_off;   // cycles left in a long receiver hold-off
  int quiet;      // cycles with no beat on either channel
  int settings_done;

  sgc_in_if texel_ch ();
  sgc_out_if pixel_ch ();
  sgc_tb_apb_if apb ();

  sky_gradient_cubemap_texel_unit u_dut (
    .clk(clk), .rst(rst), .texel_in(texel_ch.sink), .pixel_out(pixel_ch.source),
    .psel(apb.psel), .penable(apb.penable), .pwrite(apb.pwrite), .paddr(apb.paddr),
    .pwdata(apb.pwdata), .prdata(apb.prdata), .pready(apb.pready)
  );

  sky_texel_checker u_checker (
    .clk(clk), .rst(rst), .texel_in(texel_ch.sink), .pixel_out(pixel_ch.sink),
    .psel(apb.psel), .penable(apb.penable), .pwrite(apb.pwrite), .pready(apb.pready),
    .paddr(apb.paddr), .pwdata(apb.pwdata), .fail_count(fail_count),
    .pending(pending), .texels_seen(texels_seen), .pixels_seen(pixels_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off counted here when asked
  initial begin
    pixel_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        pixel_ch.ready <= 0;
      end else begin
        pixel_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no beat
  initial begin
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((texel_ch.valid && texel_ch.ready) || (pixel_ch.valid && pixel_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", quiet);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic reg_write(reg_index_t idx, logic [PDATA_W-1:0] value);
    apb.psel <= 1; apb.penable <= 0; apb.pwrite <= 1;
    apb.paddr <= PADDR_W'(int'(idx) * 8); apb.pwdata <= value;
    @(posedge clk);
    apb.penable <= 1;
    @(posedge clk);
    apb.psel <= 0; apb.penable <= 0; apb.pwrite <= 0;
  endtask

  // offer one texel beat, idling at random before it
  task automatic send_texel(logic [2:0] face, logic [9:0] col, logic [9:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      texel_ch.valid <= 0;
      @(posedge clk);
    end
    texel_ch.valid <= 1;
    texel_ch.face <= face; texel_ch.column <= col; texel_ch.row <= row;
    @(posedge clk);
    while (!texel_ch.ready) @(posedge clk);
  endtask

  // let the pipeline drain before touching registers
  task automatic drain();
    texel_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic random_burst(int count, int size);
    logic [2:0] face;
    logic [9:0] col, row;
    for (int i = 0; i < count; i++) begin
      face = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      // mostly in-range texels, sometimes anywhere in the field
      if ($urandom_range(9) == 0) begin
        col = 10'($urandom); row = 10'($urandom);
      end else begin
        col = 10'($urandom_range(size > 0 ? size - 1 : 0));
        row = 10'($urandom_range(size > 0 ? size - 1 : 0));
      end
      send_texel(face, col, row);
    end
  endtask

  initial begin
    logic [47:0] palette;
    int sizes[6];
    rst = 1;
    hold_off = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    texel_ch.valid = 0; texel_ch.face = 0; texel_ch.column = 0; texel_ch.row = 0;
    apb.psel = 0; apb.penable = 0; apb.pwrite = 0; apb.paddr = 0; apb.pwdata = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: every face incl. the unused codes, corners and centre at reset size
    for (int f = 0; f < 8; f++) begin
      send_texel(3'(f), 10'd0, 10'd0);
      send_texel(3'(f), 10'd255, 10'd255);
    end
    send_texel(FACE_POS_X, 10'd127, 10'd128);
    send_texel(FACE_POS_Z, 10'd1023, 10'd1023);   // beyond the face edge
    send_texel(FACE_NEG_X, 10'd0, 10'd1023);
    send_texel(FACE_NEG_Z, 10'd1023, 10'd0);
    send_texel(FACE_POS_X, 10'h2AA, 10'h155);
    send_texel(FACE_POS_X, 10'h155, 10'h2AA);
    drain();

    // zero size behaves as one, oversized behaves as the maximum
    reg_write(REG_FACE_SIZE, 64'd0);
    send_texel(FACE_POS_X, 10'd0, 10'd0);
    send_texel(FACE_NEG_Z, 10'd3, 10'd900);
    drain();
    reg_write(REG_FACE_SIZE, 64'h7FF);
    send_texel(FACE_POS_X, 10'd1023, 10'd0);
    send_texel(FACE_POS_Z, 10'd0, 10'd1023);
    drain();

    // settings: sizes from the extremes, colors all-ones, all-zeros and random
    sizes = '{1, 1024, 2, 7, 64, 300};
    for (int s = 0; s < 6; s++) begin
      case (s % 3)
        0: palette = '1;
        1: palette = '0;
        default: palette = {$urandom, $urandom};
      endcase
      reg_write(REG_FACE_SIZE, 64'(sizes[s]));
      reg_write(REG_SKY_TOP, {$urandom, $urandom} ^ 64'(palette));
      reg_write(REG_HORIZON, {$urandom, $urandom});
      reg_write(REG_GROUND, 64'(palette));
      case (s % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 59; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 59; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if (s == 2) hold_off = 300;   // receiver holds off while texels keep coming
      random_burst(185, sizes[s]);
      drain();   // sender pauses until every pixel has come back
    end
    settings_done = 6;

    send_idle_pct = 0; recv_stall_pct = 0;
    texel_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (pending != 0) $display("%0d pixels still outstanding", pending);
    $display("covered %0d texels, %0d pixels over %0d register settings", texels_seen,
             pixels_seen, settings_done + 3);
    $display("stall phases: none, sender idle, receiver stall, both, long hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
